FILE: sv/assert_macros.svh
// Assertion macros shared by the motor mixer RTL.
// Each macro expects clk and the active-low reset rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define PAM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Property that must hold on the edge after the trigger
`define PAM_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

FILE: sv/pam_pkg.sv
// Types, widths and register codes for the PID axis motor mixer.
// No dependencies; imported by every module of the block.
`default_nettype none

package pam_pkg;

  // Integral accumulator width (signed)
  localparam int INTEGRAL_WIDTH = 32;

  localparam int GAIN_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int DUTY_W     = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int ISUM_W     = ((INTEGRAL_WIDTH > ERR_W) ? INTEGRAL_WIDTH : ERR_W) + 1;
  localparam int PD_W       = GAIN_W + DIFF_W;
  localparam int PI_W       = GAIN_W + INTEGRAL_WIDTH;
  localparam int PP_W       = GAIN_W + ERR_W;
  localparam int PID_W      = 32;
  localparam int PSUM_W     = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'h0001;
  localparam logic [DUTY_W-1:0] HOVER_RESET = 16'h1000;
  localparam logic [DUTY_W-1:0] DUTY_MAX    = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_KD,
    REG_X_KI,
    REG_X_KP,
    REG_Y_KD,
    REG_Y_KI,
    REG_Y_KP,
    REG_HOVER
  } cfg_reg_t;

  typedef struct packed {
    logic                axis_sel;
    logic [SAMPLE_W-1:0] setpoint;
    logic [SAMPLE_W-1:0] measured;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] motor1_duty;
    logic [DUTY_W-1:0] motor2_duty;
    logic [DUTY_W-1:0] motor3_duty;
    logic [DUTY_W-1:0] motor4_duty;
    logic              speed_clipped;
  } out_word_t;

  // Gains of one axis, two's complement
  typedef struct packed {
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kp;
  } gains_t;

  typedef struct packed {
    gains_t            x;
    gains_t            y;
    logic [DUTY_W-1:0] hover;
  } cfg_t;

  // Error stage result: operands for the multipliers
  typedef struct packed {
    logic                      axis_sel;
    gains_t                    gains;
    logic [ERR_W-1:0]          err;
    logic [DIFF_W-1:0]         diff;
    logic [INTEGRAL_WIDTH-1:0] integ;
  } err_word_t;

  // Product stage result
  typedef struct packed {
    logic            axis_sel;
    logic [PD_W-1:0] prod_d;
    logic [PI_W-1:0] prod_i;
    logic [PP_W-1:0] prod_p;
  } prod_word_t;

  // Saturated PID term
  typedef struct packed {
    logic             axis_sel;
    logic [PID_W-1:0] pid;
  } pid_word_t;

endpackage

`default_nettype wire

FILE: sv/pam_cfg_regs.sv
// Configuration register bank: per-axis gains and the hover offset.
// Depends on pam_pkg.
`default_nettype none

module pam_cfg_regs
  import pam_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x.kd  <= GAIN_RESET;
      cfg_r.x.ki  <= GAIN_RESET;
      cfg_r.x.kp  <= GAIN_RESET;
      cfg_r.y.kd  <= GAIN_RESET;
      cfg_r.y.ki  <= GAIN_RESET;
      cfg_r.y.kp  <= GAIN_RESET;
      cfg_r.hover <= HOVER_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_X_KD:  cfg_r.x.kd  <= cfg_data;
        REG_X_KI:  cfg_r.x.ki  <= cfg_data;
        REG_X_KP:  cfg_r.x.kp  <= cfg_data;
        REG_Y_KD:  cfg_r.y.kd  <= cfg_data;
        REG_Y_KI:  cfg_r.y.ki  <= cfg_data;
        REG_Y_KP:  cfg_r.y.kp  <= cfg_data;
        REG_HOVER: cfg_r.hover <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/pam_error_stage.sv
// Input stage: error, derivative difference and saturating integral per axis.
// Holds the per-axis PID state. Depends on pam_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pam_error_stage
  import pam_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  input  wire cfg_t     cfg,
  output logic          s1_valid,
  input  wire logic     s1_ready,
  output err_word_t     s1_data
);

  logic [ERR_W-1:0]          prev_error_r [2];
  logic [INTEGRAL_WIDTH-1:0] integ_r      [2];
  logic                      s1_valid_r;
  err_word_t                 s1_r;

  logic                             in_fire;
  logic                             ax;
  logic [ERR_W-1:0]                 err;
  logic [ERR_W-1:0]                 prev_sel;
  logic signed [INTEGRAL_WIDTH-1:0] integ_sel;
  logic [DIFF_W-1:0]                diff;
  logic signed [ISUM_W-1:0]         isum;
  logic                             integ_ovf;
  logic [INTEGRAL_WIDTH-1:0]        integ_nxt;

  assign in_ready = !s1_valid_r || s1_ready;
  assign in_fire  = in_valid && in_ready;
  assign ax       = in_data.axis_sel;

  // Error and difference against the previous error of this axis
  assign err      = {1'b0, in_data.setpoint} - {1'b0, in_data.measured};
  assign prev_sel = prev_error_r[ax];
  assign diff     = {err[ERR_W-1], err} - {prev_sel[ERR_W-1], prev_sel};

  // Accumulate and saturate to the signed integral range
  assign integ_sel = integ_r[ax];
  assign isum      = ISUM_W'(integ_sel) + ISUM_W'($signed(err));
  assign integ_ovf = !(&isum[ISUM_W-1:INTEGRAL_WIDTH-1]) && (|isum[ISUM_W-1:INTEGRAL_WIDTH-1]);
  assign integ_nxt = !integ_ovf ? isum[INTEGRAL_WIDTH-1:0] :
                     isum[ISUM_W-1] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}} :
                                      {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};

  // Update the axis state and the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r[0] <= '0;
      prev_error_r[1] <= '0;
      integ_r[0]      <= '0;
      integ_r[1]      <= '0;
      s1_valid_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        prev_error_r[ax] <= err;
        integ_r[ax]      <= integ_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Capture the multiplier operands
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.axis_sel <= ax;
      s1_r.gains    <= ax ? cfg.y : cfg.x;
      s1_r.err      <= err;
      s1_r.diff     <= diff;
      s1_r.integ    <= integ_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_r;

  `PAM_ASSERT_NEXT(a_state_tracks_word, in_fire, (prev_error_r[s1_r.axis_sel] == s1_r.err) && (integ_r[s1_r.axis_sel] == s1_r.integ), "axis state does not match the accepted word")
  `PAM_ASSERT_NEXT(a_stage_loaded, in_fire, s1_valid_r, "accepted word missing from the error stage")

endmodule

`default_nettype wire

FILE: sv/pam_product_stage.sv
// Multiplier stage: the three gain products of the PID term.
// Depends on pam_pkg.
`default_nettype none

module pam_product_stage
  import pam_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      s1_valid,
  output logic           s1_ready,
  input  wire err_word_t s1_data,
  output logic           s2_valid,
  input  wire logic      s2_ready,
  output prod_word_t     s2_data
);

  logic       s2_valid_r;
  prod_word_t s2_r;

  logic                   s1_fire;
  logic signed [PD_W-1:0] prod_d;
  logic signed [PI_W-1:0] prod_i;
  logic signed [PP_W-1:0] prod_p;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign s1_fire  = s1_valid && s1_ready;

  // Full-width signed products
  assign prod_d = $signed(s1_data.gains.kd) * $signed(s1_data.diff);
  assign prod_i = $signed(s1_data.gains.ki) * $signed(s1_data.integ);
  assign prod_p = $signed(s1_data.gains.kp) * $signed(s1_data.err);

  // Advance the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_fire) begin
      s2_valid_r <= 1'b1;
    end else if (s2_ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  // Register the products
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_r.axis_sel <= s1_data.axis_sel;
      s2_r.prod_d   <= prod_d;
      s2_r.prod_i   <= prod_i;
      s2_r.prod_p   <= prod_p;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_r;

endmodule

`default_nettype wire

FILE: sv/pam_mix_stage.sv
// Sum and saturate the PID term, then form the speed and mix the four duties.
// Two register stages. Depends on pam_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pam_mix_stage
  import pam_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        s2_valid,
  output logic             s2_ready,
  input  wire prod_word_t  s2_data,
  input  wire logic [DUTY_W-1:0] hover,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data
);

  logic      s3_valid_r;
  pid_word_t s3_r;
  logic      out_valid_r;
  out_word_t out_r;

  logic                     s3_ready;
  logic                     s2_fire;
  logic                     s3_fire;
  logic signed [PSUM_W-1:0] pid_sum;
  logic                     pid_ovf;
  logic [PID_W-1:0]         pid_nxt;
  logic                     neg;
  logic [PID_W-1:0]         mag;
  logic [PID_W:0]           spd;
  logic                     clip;
  logic [DUTY_W-1:0]        full;
  logic [DUTY_W-1:0]        low;
  out_word_t                out_nxt;

  assign s3_ready = !out_valid_r || out_ready;
  assign s2_ready = !s3_valid_r || s3_ready;
  assign s2_fire  = s2_valid && s2_ready;
  assign s3_fire  = s3_valid_r && s3_ready;

  // Sum the products and saturate to 32 bits
  assign pid_sum = $signed(s2_data.prod_d) + $signed(s2_data.prod_i) + $signed(s2_data.prod_p);
  assign pid_ovf = !(&pid_sum[PSUM_W-1:PID_W-1]) && (|pid_sum[PSUM_W-1:PID_W-1]);
  assign pid_nxt = !pid_ovf ? pid_sum[PID_W-1:0] :
                   pid_sum[PSUM_W-1] ? {1'b1, {(PID_W-1){1'b0}}} :
                                       {1'b0, {(PID_W-1){1'b1}}};

  // Magnitude plus hover offset, clipped to the duty range
  assign neg  = s3_r.pid[PID_W-1];
  assign mag  = neg ? (PID_W'(0) - s3_r.pid) : s3_r.pid;
  assign spd  = {1'b0, mag} + (PID_W + 1)'(hover);
  assign clip = |spd[PID_W:DUTY_W];
  assign full = clip ? DUTY_MAX : spd[DUTY_W-1:0];
  assign low  = {3'b000, full[DUTY_W-1:3]};

  // Pick full or reduced speed per motor from sign and axis
  always_comb begin
    out_nxt.speed_clipped = clip;
    if (neg) begin
      out_nxt.motor1_duty = full;
      out_nxt.motor2_duty = s3_r.axis_sel ? low : full;
      out_nxt.motor3_duty = low;
      out_nxt.motor4_duty = s3_r.axis_sel ? full : low;
    end else begin
      out_nxt.motor1_duty = low;
      out_nxt.motor2_duty = s3_r.axis_sel ? full : low;
      out_nxt.motor3_duty = full;
      out_nxt.motor4_duty = s3_r.axis_sel ? low : full;
    end
  end

  // Advance both valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_fire) begin
        s3_valid_r <= 1'b1;
      end else if (s3_ready) begin
        s3_valid_r <= 1'b0;
      end
      if (s3_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the payload registers
  always_ff @(posedge clk) begin
    if (s2_fire) begin
      s3_r.axis_sel <= s2_data.axis_sel;
      s3_r.pid      <= pid_nxt;
    end
    if (s3_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PAM_ASSERT(a_mix_pairs, !out_valid_r || ((out_r.motor2_duty == out_r.motor1_duty && out_r.motor4_duty == out_r.motor3_duty) || (out_r.motor4_duty == out_r.motor1_duty && out_r.motor2_duty == out_r.motor3_duty)), "motor duties are not paired")
  `PAM_ASSERT(a_clip_full, !(out_valid_r && out_r.speed_clipped) || out_r.motor1_duty == DUTY_MAX || out_r.motor3_duty == DUTY_MAX, "clipped speed not at full duty")

endmodule

`default_nettype wire

FILE: sv/pid_axis_motor_mixer_unit.sv
// Top level of the PID axis motor mixer: config bank and the four-stage datapath.
// Depends on pam_pkg, assert_macros.svh and the pam_* stage modules.
//
// Usage:
//   in_valid/in_ready/in_data carry one sensor word: axis, setpoint, measured.
//   out_valid/out_ready/out_data carry four motor duties and a clip flag.
//   cfg_wr_en/cfg_index/cfg_data write a gain or the hover offset;
//   write only while no word is in flight. Unknown indexes are ignored.
// Timing:
//   A word passes the error, product, PID and output registers to out_valid.
//   One word per cycle unless the output stalls; the error stage updates the
//   per-axis state at the accept edge, so the next word on the same axis sees it
//   at once. The 16 x 32 integral product in the multiplier stage sets the clock.
// Reset and stalls:
//   Reset clears gains to 1, hover offset to 0x1000, integrals and previous
//   errors to zero, and empties the pipeline.
//   A stalled receiver holds the output word; stages fill behind it and
//   in_ready drops once all four stages hold a word.
`default_nettype none
`include "assert_macros.svh"

module pid_axis_motor_mixer_unit
  import pam_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       s1_valid;
  logic       s1_ready;
  err_word_t  s1_data;
  logic       s2_valid;
  logic       s2_ready;
  prod_word_t s2_data;

  pam_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pam_error_stage u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data)
  );

  pam_product_stage u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data)
  );

  pam_mix_stage u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_data   (s2_data),
    .hover     (cfg.hover),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `PAM_ASSERT(a_ready_when_empty, out_valid || in_ready, "input stalled with an empty output register")

endmodule

`default_nettype wire

FILE: dv/pam_mixer_checker.sv
`timescale 1ns / 100ps
// Checker for the PID axis motor mixer: mirrors the register bank and per-axis
// PID state, predicts the duty word for each accepted sensor word and compares.
// Depends on pam_pkg only.

module pam_mixer_checker
  import pam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  localparam bit     AXIS_X = 1'b0;
  localparam bit     AXIS_Y = 1'b1;
  localparam longint PID_HI = 64'sd2147483647;
  localparam longint PID_LO = -64'sd2147483648;
  localparam longint INTEG_HI = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1;
  localparam longint INTEG_LO = -INTEG_HI - 64'sd1;
  localparam longint SPEED_MAX = 64'sd65535;

  // Mirrored registers, indexed by axis
  logic signed [GAIN_W-1:0] kd_gain [2];
  logic signed [GAIN_W-1:0] ki_gain [2];
  logic signed [GAIN_W-1:0] kp_gain [2];
  logic [DUTY_W-1:0]        hover;

  // Per-axis controller state
  longint    last_err [2];
  longint    err_sum  [2];
  out_word_t expected_duties [$];

  // Advance the axis state by one sensor word and return the duties it drives
  function automatic out_word_t predict_duties(in_word_t w);
    bit                ax;
    longint            err, diff, integ, pid, mag, speed;
    bit                neg, clip;
    logic [DUTY_W-1:0] full, low;
    out_word_t         r;
    ax    = w.axis_sel;
    err   = longint'(w.setpoint) - longint'(w.measured);
    diff  = err - last_err[ax];
    integ = err_sum[ax] + err;
    if (integ > INTEG_HI) integ = INTEG_HI;
    if (integ < INTEG_LO) integ = INTEG_LO;
    err_sum[ax]  = integ;
    last_err[ax] = err;

    pid = longint'(kd_gain[ax]) * diff + longint'(ki_gain[ax]) * integ
        + longint'(kp_gain[ax]) * err;
    if (pid > PID_HI) pid = PID_HI;
    if (pid < PID_LO) pid = PID_LO;
    neg   = pid < 0;
    mag   = neg ? -pid : pid;
    speed = mag + longint'(hover);
    clip  = speed > SPEED_MAX;
    if (clip) speed = SPEED_MAX;
    full = speed[DUTY_W-1:0];
    low  = full >> 3;

    // Sign and axis pick the motor pair that runs at full speed
    if (neg) begin
      r.motor1_duty = full;
      r.motor2_duty = (ax == AXIS_Y) ? low : full;
      r.motor3_duty = low;
      r.motor4_duty = (ax == AXIS_Y) ? full : low;
    end else begin
      r.motor1_duty = low;
      r.motor2_duty = (ax == AXIS_Y) ? full : low;
      r.motor3_duty = full;
      r.motor4_duty = (ax == AXIS_Y) ? low : full;
    end
    r.speed_clipped = clip;
    return r;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      kd_gain  = '{GAIN_RESET, GAIN_RESET};
      ki_gain  = '{GAIN_RESET, GAIN_RESET};
      kp_gain  = '{GAIN_RESET, GAIN_RESET};
      hover    = HOVER_RESET;
      last_err = '{0, 0};
      err_sum  = '{0, 0};
      expected_duties.delete();
      mismatches = 0;
    end else begin
      // Compare a delivered word against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          $error("duty word delivered with no sensor word outstanding");
          mismatches++;
        end else begin
          want = expected_duties.pop_front();
          check_field("motor1_duty", want.motor1_duty, out_data.motor1_duty);
          check_field("motor2_duty", want.motor2_duty, out_data.motor2_duty);
          check_field("motor3_duty", want.motor3_duty, out_data.motor3_duty);
          check_field("motor4_duty", want.motor4_duty, out_data.motor4_duty);
          check_field("speed_clipped", want.speed_clipped, out_data.speed_clipped);
        end
      end

      if (in_valid && in_ready)
        expected_duties.push_back(predict_duties(in_data));

      // Track register writes; unmapped indexes fall through
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_X_KD:  kd_gain[AXIS_X] = cfg_data;
          REG_X_KI:  ki_gain[AXIS_X] = cfg_data;
          REG_X_KP:  kp_gain[AXIS_X] = cfg_data;
          REG_Y_KD:  kd_gain[AXIS_Y] = cfg_data;
          REG_Y_KI:  ki_gain[AXIS_Y] = cfg_data;
          REG_Y_KP:  kp_gain[AXIS_Y] = cfg_data;
          REG_HOVER: hover = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_duties.size();
  end

endmodule

FILE: dv/pid_axis_motor_mixer_unit_test.sv
`timescale 1ns / 100ps
// Test top for pid_axis_motor_mixer_unit: clock, reset, sensor word stimulus,
// register programming and the verdict. Depends on pam_pkg, the unit and pam_mixer_checker.

module pid_axis_motor_mixer_unit_test;
  import pam_pkg::*;

  localparam bit                    AXIS_X       = 1'b0;
  localparam bit                    AXIS_Y       = 1'b1;
  localparam logic [CFG_IDX_W-1:0]  REG_UNMAPPED = 3'd7;
  localparam logic [GAIN_W-1:0]     GAIN_MAX     = 16'h7FFF;
  localparam logic [GAIN_W-1:0]     GAIN_MIN     = 16'h8000;
  localparam logic [GAIN_W-1:0]     GAIN_ZERO    = 16'h0000;
  localparam logic [SAMPLE_W-1:0]   SAMPLE_MAX   = 16'hFFFF;
  localparam int                    STALL_LIMIT  = 5000;
  localparam int                    RAMP_WORDS   = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_word_t              in_data   = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_word_t             out_data;
  logic                  out_ready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit gaps_on      = 1'b1;
  int words_in     = 0;
  int words_out    = 0;
  int quiet_cycles = 0;
  int mismatches;
  int pending;

  always #5 clk = ~clk;

  pid_axis_motor_mixer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pam_mixer_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Stall the duty channel now and then
  always @(posedge clk) begin
    out_ready <= gaps_on ? ($urandom_range(99) >= 6) : 1'b1;
  end

  // Count words both ways; drop out if the block goes silent
  always @(posedge clk) begin
    if (in_valid && in_ready) words_in <= words_in + 1;
    if (out_valid && out_ready) words_out <= words_out + 1;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t mk_word(bit ax, logic [SAMPLE_W-1:0] sp,
                                       logic [SAMPLE_W-1:0] ms);
    in_word_t w;
    w.axis_sel = ax;
    w.setpoint = sp;
    w.measured = ms;
    return w;
  endfunction

  // Mix of wide, near-balanced, extreme and zero-error sensor words
  function automatic in_word_t rand_word();
    in_word_t w;
    int       pick;
    w.axis_sel = 1'($urandom_range(1));
    w.setpoint = 16'($urandom_range(SAMPLE_MAX));
    w.measured = 16'($urandom_range(SAMPLE_MAX));
    pick = $urandom_range(9);
    if (pick >= 5 && pick <= 7)
      w.measured = w.setpoint + 16'($urandom_range(64)) - 16'd32;
    else if (pick == 8) begin
      w.setpoint = $urandom_range(1) ? SAMPLE_MAX : '0;
      w.measured = $urandom_range(1) ? SAMPLE_MAX : '0;
    end else if (pick == 9)
      w.measured = w.setpoint;
    return w;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain(bit narrow);
    if (narrow) return 16'($urandom_range(8)) - 16'd4;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // Hold the word until accepted, with an occasional idle cycle up front
  task automatic send_word(in_word_t w);
    while (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_words(int count);
    repeat (count) send_word(rand_word());
  endtask

  // Drop valid and wait until every duty word is back and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_out != words_in) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Program the whole bank; a stray write to the unmapped index goes in the middle
  task automatic program_regs(logic [GAIN_W-1:0] xkd, logic [GAIN_W-1:0] xki,
                              logic [GAIN_W-1:0] xkp, logic [GAIN_W-1:0] ykd,
                              logic [GAIN_W-1:0] yki, logic [GAIN_W-1:0] ykp,
                              logic [DUTY_W-1:0] hov);
    write_reg(REG_X_KD, xkd);
    write_reg(REG_X_KI, xki);
    write_reg(REG_X_KP, xkp);
    write_reg(REG_UNMAPPED, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_Y_KD, ykd);
    write_reg(REG_Y_KI, yki);
    write_reg(REG_Y_KP, ykp);
    write_reg(REG_HOVER, hov);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    bit narrow;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gains: extremes, both signs, both axes, zero error
    send_word(mk_word(AXIS_X, 16'h0000, 16'h0000));
    send_word(mk_word(AXIS_X, SAMPLE_MAX, 16'h0000));
    send_word(mk_word(AXIS_X, 16'h0000, SAMPLE_MAX));
    send_word(mk_word(AXIS_X, SAMPLE_MAX, SAMPLE_MAX));
    send_word(mk_word(AXIS_X, 16'h0000, 16'h0001));
    send_word(mk_word(AXIS_X, 16'h0001, 16'h0000));
    send_word(mk_word(AXIS_X, 16'h8000, 16'h7FFF));
    send_word(mk_word(AXIS_X, 16'h8000, 16'h0000));
    send_word(mk_word(AXIS_X, 16'h0000, 16'h8000));
    send_word(mk_word(AXIS_X, 16'd12345, 16'd12345));
    send_word(mk_word(AXIS_Y, 16'h0000, 16'h0000));
    send_word(mk_word(AXIS_Y, SAMPLE_MAX, 16'h0000));
    send_word(mk_word(AXIS_Y, 16'h0000, SAMPLE_MAX));
    send_word(mk_word(AXIS_Y, SAMPLE_MAX, SAMPLE_MAX));
    send_word(mk_word(AXIS_Y, 16'd100, 16'd200));
    send_word(mk_word(AXIS_Y, 16'd200, 16'd100));
    send_word(mk_word(AXIS_Y, 16'hAAAA, 16'h5555));
    send_word(mk_word(AXIS_Y, 16'h5555, 16'hAAAA));

    // Largest positive gains, full hover: PID and speed overflow
    settle();
    program_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, SAMPLE_MAX);
    random_words(100);

    // Most negative gains, no hover, back to back with no stalls
    settle();
    gaps_on = 1'b0;
    program_regs(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, 16'h0000);
    random_words(100);
    gaps_on = 1'b1;

    // Random banks, alternating wide gains with small ones that keep PID in range
    for (int p = 0; p < 4; p++) begin
      narrow = p[0];
      settle();
      program_regs(rand_gain(narrow), rand_gain(narrow), rand_gain(narrow),
                   rand_gain(narrow), rand_gain(narrow), rand_gain(narrow),
                   16'($urandom_range(16'hFFFF)));
      random_words(100);
    end

    // Ramp both integrals in opposite directions with the largest error; a
    // unit ki against the most negative kp keeps the PID term near its rail
    settle();
    program_regs(GAIN_ZERO, 16'h0001, GAIN_MIN, GAIN_ZERO, 16'h0001, GAIN_MIN,
                 16'($urandom_range(16'h1000)));
    repeat (RAMP_WORDS) begin
      send_word(mk_word(AXIS_X, SAMPLE_MAX, 16'h0000));
      send_word(mk_word(AXIS_Y, 16'h0000, SAMPLE_MAX));
    end
    // Back off the ramp
    repeat (10) begin
      send_word(mk_word(AXIS_X, 16'h0000, 16'($urandom_range(SAMPLE_MAX))));
      send_word(mk_word(AXIS_Y, 16'($urandom_range(SAMPLE_MAX)), 16'h0000));
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
